// ----- design/tcs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the text comment stripper.
package tcs_pkg;

  // Fixed widths of the result fields on the output stream and of the line offset
  localparam int LINE_OUT_W = 32;
  localparam int COL_OUT_W  = 24;
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 16;

  // Characters that steer the scanner
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  // Scanner modes
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  // Result buffer geometry
  localparam int BUF_DEPTH = 3;
  localparam int BUF_CNT_W = 2;

  // One result beat
  typedef struct packed {
    logic [COL_OUT_W-1:0]  column_number;
    logic [LINE_OUT_W-1:0] line_number;
    logic [BYTE_W-1:0]     out_byte;
    logic                  is_end;
    logic                  last_of_run;
  } tcs_result_t;

  // Results handed from the scanner to the buffer in the same cycle
  typedef struct packed {
    logic [1:0]  count;
    tcs_result_t first;
    tcs_result_t second;
  } tcs_push_t;

endpackage

// ----- design/tcs_parser.sv -----
`timescale 1ns / 1ps
// Input register, comment scanner state and line/column counters.
module tcs_parser import tcs_pkg::*; #(
  parameter int LINE_WIDTH   = 32,
  parameter int COLUMN_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic                in_eos,
  input  logic                cfg_write,
  input  logic [OFFSET_W-1:0] cfg_offset,
  input  logic                room,
  output tcs_push_t           push
);

  logic                    stage_valid;
  logic [BYTE_W-1:0]       stage_byte;
  logic                    stage_eos;

  logic [1:0]              mode;
  logic [1:0]              mode_next;
  logic                    slash;
  logic                    slash_next;
  logic                    star;
  logic                    star_next;
  logic [LINE_WIDTH-1:0]   line_cnt;
  logic [LINE_WIDTH-1:0]   line_cnt_next;
  logic [COLUMN_WIDTH-1:0] col_cnt;
  logic [COLUMN_WIDTH-1:0] col_cnt_next;

  logic                    advance;
  logic                    is_nl;
  logic                    ends;
  logic [1:0]              n_res;
  logic [BYTE_W-1:0]       byte0;
  logic [BYTE_W-1:0]       byte1;
  logic                    end0;
  logic                    end1;
  logic [LINE_OUT_W-1:0]   line_out;
  logic [COL_OUT_W-1:0]    col_out;

  // Move the held beat on whenever the buffer has room for two results
  assign advance  = stage_valid && room;
  assign in_ready = !stage_valid || room;

  // Hold the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
      stage_eos  <= in_eos;
    end
  end

  assign is_nl = (stage_byte == CHAR_NL);
  assign ends  = stage_eos || (stage_byte == CHAR_NUL);

  // Counters: a newline bumps the line and clears the column; both saturate
  always_comb begin
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    if (!stage_eos) begin
      if (is_nl) begin
        if (!(&line_cnt)) begin
          line_cnt_next = line_cnt + 1'b1;
        end
        col_cnt_next = '0;
      end else if (!(&col_cnt)) begin
        col_cnt_next = col_cnt + 1'b1;
      end
    end
  end

  // Scanner: decide the mode change and the results of this beat
  always_comb begin
    mode_next  = mode;
    slash_next = slash;
    star_next  = star;
    n_res      = 2'd0;
    byte0      = stage_byte;
    byte1      = stage_byte;
    end0       = 1'b0;
    end1       = 1'b0;
    if (ends) begin
      if (slash && mode == MODE_TEXT) begin
        n_res = 2'd2;
        byte0 = CHAR_SLASH;
        byte1 = CHAR_NUL;
        end1  = 1'b1;
      end else begin
        n_res = 2'd1;
        byte0 = CHAR_NUL;
        end0  = 1'b1;
      end
      mode_next  = MODE_TEXT;
      slash_next = 1'b0;
      star_next  = 1'b0;
    end else begin
      unique case (mode)
        MODE_LINE: begin
          if (is_nl) begin
            mode_next = MODE_TEXT;
            n_res     = 2'd1;
          end
        end
        MODE_BLOCK: begin
          if (star && stage_byte == CHAR_SLASH) begin
            mode_next = MODE_TEXT;
            star_next = 1'b0;
          end else begin
            star_next = (stage_byte == CHAR_STAR);
          end
        end
        MODE_TEXT: begin
          if (slash) begin
            slash_next = 1'b0;
            if (stage_byte == CHAR_SLASH) begin
              mode_next = MODE_LINE;
            end else if (stage_byte == CHAR_STAR) begin
              mode_next = MODE_BLOCK;
              star_next = 1'b0;
            end else begin
              n_res = 2'd2;
              byte0 = CHAR_SLASH;
            end
          end else if (stage_byte == CHAR_SLASH) begin
            slash_next = 1'b1;
          end else begin
            n_res = 2'd1;
          end
        end
        default: begin
          mode_next = MODE_TEXT;
        end
      endcase
    end
  end

  // Results carry the counters after this byte, cut or widened to the field
  assign line_out = LINE_OUT_W'(line_cnt_next);
  assign col_out  = COL_OUT_W'(col_cnt_next);

  always_comb begin
    push.count                = advance ? n_res : 2'd0;
    push.first.out_byte       = byte0;
    push.first.line_number    = line_out;
    push.first.column_number  = col_out;
    push.first.is_end         = end0;
    push.first.last_of_run    = (n_res == 2'd1);
    push.second.out_byte      = byte1;
    push.second.line_number   = line_out;
    push.second.column_number = col_out;
    push.second.is_end        = end1;
    push.second.last_of_run   = 1'b1;
  end

  // Update scanner state; a register write restarts the stream
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_TEXT;
      slash    <= 1'b0;
      star     <= 1'b0;
      line_cnt <= LINE_WIDTH'(1);
      col_cnt  <= '0;
    end else if (cfg_write) begin
      mode     <= MODE_TEXT;
      slash    <= 1'b0;
      star     <= 1'b0;
      line_cnt <= LINE_WIDTH'({1'b0, cfg_offset} + 17'd1);
      col_cnt  <= '0;
    end else if (advance) begin
      mode     <= mode_next;
      slash    <= slash_next;
      star     <= star_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
    end
  end

endmodule

// ----- design/tcs_out_buf.sv -----
`timescale 1ns / 1ps
// Three-entry result buffer: up to two writes and one read per cycle.
module tcs_out_buf import tcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tcs_push_t   push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output tcs_result_t out_head
);

  tcs_result_t          entries      [BUF_DEPTH];
  tcs_result_t          entries_next [BUF_DEPTH];
  logic [BUF_CNT_W-1:0] count;
  logic [BUF_CNT_W-1:0] count_next;
  logic [BUF_CNT_W-1:0] base;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_head  = entries[0];
  assign pop       = out_valid && out_ready;
  assign room      = (count < BUF_CNT_W'(BUF_DEPTH - 1));
  assign base      = count - BUF_CNT_W'(pop);

  // Shift down on a read, then append new results after the survivors
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (pop && i < BUF_DEPTH - 1) begin
        entries_next[i] = entries[i + 1];
      end else begin
        entries_next[i] = entries[i];
      end
      if (push.count != 2'd0 && BUF_CNT_W'(i) == base) begin
        entries_next[i] = push.first;
      end
      if (push.count == 2'd2 && BUF_CNT_W'(i) == base + 1'b1) begin
        entries_next[i] = push.second;
      end
    end
    count_next = base + push.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

endmodule

// ----- design/text_comment_stripper.sv -----
`timescale 1ns / 1ps
// Top level of the text comment stripper.
// Takes one text byte per clock while the buffer has room and passes it on
// with line and block comments removed, each result tagged with the line and
// column after the byte read. An input beat is registered, scanned and its
// results written into a three-entry output buffer. The output port moves one
// result per cycle while the receiver is ready, and that port sets the rate:
// a byte that gives two results (a held slash flushed before plain text or
// before the end marker) needs two output beats. Input is taken whenever the
// input register is empty or the buffer holds at most one result. A register
// write restarts the stream and is always ready.
module text_comment_stripper import tcs_pkg::*; #(
  parameter int LINE_WIDTH   = 32,
  parameter int COLUMN_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] in_byte
  input  logic                s_axis_tlast,  // end_of_stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // [7:0] out_byte, [39:8] line_number,
                                             // [63:40] column_number
  output logic                m_axis_tuser,  // is_end
  output logic                m_axis_tlast,  // last_of_run
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OFFSET_W-1:0] cfg_data       // first_line_offset
);

  tcs_push_t   push;
  tcs_result_t head;
  logic        room;

  assign cfg_ready = 1'b1;

  tcs_parser #(
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_eos     (s_axis_tlast),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_offset (cfg_data),
    .room       (room),
    .push       (push)
  );

  tcs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_head  (head)
  );

  // Pack the head result onto the output stream
  assign m_axis_tdata = {head.column_number, head.line_number, head.out_byte};
  assign m_axis_tuser = head.is_end;
  assign m_axis_tlast = head.last_of_run;

endmodule

// ----- design/tcs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the text comment stripper, bound to the top level.
module tcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result beat holds its contents
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // The end marker carries a zero byte and closes its run
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00 && m_axis_tlast)
    else $error("end marker malformed");

  // A passed newline was the last byte read, so the column is zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[7:0] == 8'h0A
      |-> m_axis_tdata[63:40] == 24'd0)
    else $error("newline with non-zero column");

  // The buffer is empty straight after reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

endmodule

bind text_comment_stripper tcs_checker u_tcs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb_text_comment_stripper.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the text comment stripper: byte stream in, stripped results out.
module tb_text_comment_stripper import tcs_pkg::*;;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;

  // Tracks the scanner state for every accepted byte and holds the results it should give
  class strip_scoreboard;
    logic [OFFSET_W-1:0]   offset;
    logic [1:0]            mode;
    bit                    slash_held;
    bit                    star_seen;
    logic [LINE_OUT_W-1:0] line_cnt;
    logic [COL_OUT_W-1:0]  col_cnt;
    tcs_result_t           awaited_q[$];
    int                    errors;

    function new();
      offset = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode       = MODE_TEXT;
      slash_held = 1'b0;
      star_seen  = 1'b0;
      line_cnt   = LINE_OUT_W'(offset) + 1;
      col_cnt    = '0;
    endfunction

    function void set_offset(logic [OFFSET_W-1:0] value);
      offset = value;
      restart();
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function tcs_result_t make_result(logic [BYTE_W-1:0] b, logic is_end);
      tcs_result_t r;
      r.out_byte      = b;
      r.line_number   = line_cnt;
      r.column_number = col_cnt;
      r.is_end        = is_end;
      r.last_of_run   = 1'b0;
      return r;
    endfunction

    // Advance the counters and scanner for one accepted beat, queue what it gives
    function void note_byte(logic [BYTE_W-1:0] b, logic eos);
      tcs_result_t res [2];
      int n;
      n = 0;
      if (!eos) begin
        if (b == CHAR_NL) begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = '0;
        end else if (col_cnt != '1) begin
          col_cnt++;
        end
      end
      if (eos || b == CHAR_NUL) begin
        if (slash_held && mode == MODE_TEXT) begin
          res[n] = make_result(CHAR_SLASH, 1'b0);
          n++;
        end
        res[n]     = make_result(CHAR_NUL, 1'b1);
        n++;
        mode       = MODE_TEXT;
        slash_held = 1'b0;
        star_seen  = 1'b0;
      end else if (mode == MODE_LINE) begin
        if (b == CHAR_NL) begin
          mode = MODE_TEXT;
          res[n] = make_result(b, 1'b0);
          n++;
        end
      end else if (mode == MODE_BLOCK) begin
        if (star_seen && b == CHAR_SLASH) begin
          mode      = MODE_TEXT;
          star_seen = 1'b0;
        end else begin
          star_seen = (b == CHAR_STAR);
        end
      end else if (slash_held) begin
        slash_held = 1'b0;
        if (b == CHAR_SLASH) begin
          mode = MODE_LINE;
        end else if (b == CHAR_STAR) begin
          mode      = MODE_BLOCK;
          star_seen = 1'b0;
        end else begin
          res[0] = make_result(CHAR_SLASH, 1'b0);
          res[1] = make_result(b, 1'b0);
          n = 2;
        end
      end else if (b == CHAR_SLASH) begin
        slash_held = 1'b1;
      end else begin
        res[n] = make_result(b, 1'b0);
        n++;
      end
      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) awaited_q.push_back(res[i]);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    // Compare one result beat with the oldest queued result
    function void check_result(logic [63:0] data, logic user, logic last);
      tcs_result_t want;
      if (awaited_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with none awaited, expected nothing, got data %0h end %0b",
                 $time, data, user);
        return;
      end
      want = awaited_q.pop_front();
      compare_field("out_byte", 32'(want.out_byte), 32'(data[7:0]));
      compare_field("line_number", want.line_number, data[39:8]);
      compare_field("column_number", 32'(want.column_number), 32'(data[63:40]));
      compare_field("is_end", 32'(want.is_end), 32'(user));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data = '0;

  strip_scoreboard sb;
  bit              steady = 1'b0;
  int              items_sent = 0;
  int              cycle_count = 0;
  int              stall_left = 0;

  text_comment_stripper dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the result side in short random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every result beat
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Offer one byte, with an occasional gap ahead of it, and hold it until taken
  task automatic send(input logic [7:0] b, input logic eos);
    @(negedge clk);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, eos);
    items_sent++;
  endtask

  // Stop sending and wait for every queued result, then a settling margin
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_offset(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Plain text byte: never zero or slash, newline only when allowed
  function automatic logic [7:0] pick_text(bit allow_nl);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CHAR_SLASH || (!allow_nl && b == CHAR_NL));
    return b;
  endfunction

  // Mostly well-formed text and comments with random content, some noise
  task automatic random_run(input int budget);
    int start;
    int pick;
    int len;
    int sel;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(1, 8);
        repeat (len) send(($urandom_range(0, 5) == 0) ? CHAR_NL : pick_text(1'b0), 1'b0);
      end else if (pick < 55) begin
        send(CHAR_SLASH, 1'b0);
        send(CHAR_SLASH, 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) send(($urandom_range(0, 4) == 0) ? CHAR_SLASH : pick_text(1'b0), 1'b0);
        if ($urandom_range(0, 7) != 0) send(CHAR_NL, 1'b0);
      end else if (pick < 75) begin
        send(CHAR_SLASH, 1'b0);
        send(CHAR_STAR, 1'b0);
        len = $urandom_range(0, 8);
        repeat (len) begin
          sel = $urandom_range(0, 5);
          send((sel == 0) ? CHAR_STAR : (sel == 1) ? CHAR_SLASH : pick_text(1'b1), 1'b0);
        end
        if ($urandom_range(0, 7) != 0) begin
          send(CHAR_STAR, 1'b0);
          send(CHAR_SLASH, 1'b0);
        end
      end else if (pick < 85) begin
        send(CHAR_SLASH, 1'b0);
        send(pick_text(1'b1), 1'b0);
      end else if (pick < 91) begin
        if ($urandom_range(0, 1) == 0) send(8'($urandom_range(0, 255)), 1'b1);
        else send(CHAR_NUL, 1'b0);
      end else begin
        send(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes and each scanner path
    send(8'h61, 1'b0);
    send(8'hFF, 1'b0);
    // slash followed by text gives two results
    send(CHAR_SLASH, 1'b0);
    send(8'h62, 1'b0);
    // line comment, newline passed on
    send(CHAR_SLASH, 1'b0);
    send(CHAR_SLASH, 1'b0);
    send(8'h78, 1'b0);
    send(CHAR_STAR, 1'b0);
    send(CHAR_NL, 1'b0);
    // opening star does not close the block comment
    send(CHAR_SLASH, 1'b0);
    send(CHAR_STAR, 1'b0);
    send(CHAR_SLASH, 1'b0);
    send(8'h71, 1'b0);
    send(CHAR_STAR, 1'b0);
    send(CHAR_STAR, 1'b0);
    send(CHAR_SLASH, 1'b0);
    send(8'h7A, 1'b0);
    // held slash flushed before the end marker, by flag and by zero byte
    send(CHAR_SLASH, 1'b0);
    send(8'hA5, 1'b1);
    send(CHAR_SLASH, 1'b0);
    send(CHAR_NUL, 1'b0);
    // end inside a block comment, then inside a line comment
    send(CHAR_SLASH, 1'b0);
    send(CHAR_STAR, 1'b0);
    send(8'h5A, 1'b1);
    send(CHAR_SLASH, 1'b0);
    send(CHAR_SLASH, 1'b0);
    send(CHAR_NUL, 1'b0);

    // Random phases over several line offsets
    write_offset(16'hFFFF);
    random_run(450);
    write_offset(16'h0000);
    random_run(450);
    write_offset(16'($urandom_range(2, 65534)));
    random_run(450);
    write_offset(16'h0001);
    steady = 1'b1;
    random_run(300);

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tcs_pkg.sv
design/tcs_parser.sv
design/tcs_out_buf.sv
design/text_comment_stripper.sv
design/tcs_checker.sv
test/tb_text_comment_stripper.sv
